// ----- design/huffman_tree_decoder_defines.svh -----
// Assertion macros used by the decoder control module.
// Each expects clk and rst in scope.
`ifndef HUFFMAN_TREE_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_DECODER_DEFINES_SVH

// same-cycle implication
`define HUFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HUFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/hufd_pkg.sv -----
package hufd_pkg;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_DATA  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // field write enables of the node store
  typedef logic [2:0] fld_mask_t;
  localparam fld_mask_t WR_NONE  = 3'b000;
  localparam fld_mask_t WR_LEFT  = 3'b001;
  localparam fld_mask_t WR_RIGHT = 3'b010;
  localparam fld_mask_t WR_SYM   = 3'b100;
  localparam fld_mask_t WR_ALL   = 3'b111;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_len;
    logic [7:0]  data_byte;
    logic [3:0]  valid_bits;
  } in_item_t;

  typedef struct packed {
    logic [6:0] symbol_out;
    logic       error;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC_BIT,
    ST_DEC_CHK,
    ST_LD_RD,
    ST_LD_BIT,
    ST_LD_LINK,
    ST_LD_SYM,
    ST_FLUSH
  } state_t;

  // sequencer to result buffer
  typedef struct packed {
    logic       push;
    logic       flush;
    logic [6:0] symbol;
    logic       error;
  } res_req_t;

  // result buffer to sequencer
  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } res_stat_t;

endpackage

// ----- design/hufd_node_mem.sv -----
module hufd_node_mem #(
  parameter int NUM_NODES = 256,
  localparam int NW = $clog2(NUM_NODES)
) (
  input  logic                clk,
  input  hufd_pkg::fld_mask_t wr_en,
  input  logic [NW-1:0]       wr_addr,
  input  logic [NW-1:0]       wr_child,
  input  logic [6:0]          wr_sym,
  input  logic [NW-1:0]       rd_addr,
  output logic [NW-1:0]       rd_left,
  output logic [NW-1:0]       rd_right,
  output logic [6:0]          rd_sym
);
  import hufd_pkg::*;

  logic [NW-1:0] left_child  [NUM_NODES];
  logic [NW-1:0] right_child [NUM_NODES];
  logic [6:0]    leaf_symbol [NUM_NODES];

  always_ff @(posedge clk) begin
    if ((wr_en & WR_LEFT) != WR_NONE) begin
      left_child[wr_addr] <= wr_child;
    end
    if ((wr_en & WR_RIGHT) != WR_NONE) begin
      right_child[wr_addr] <= wr_child;
    end
    if ((wr_en & WR_SYM) != WR_NONE) begin
      leaf_symbol[wr_addr] <= wr_sym;
    end
  end

  always_ff @(posedge clk) begin
    rd_left  <= left_child[rd_addr];
    rd_right <= right_child[rd_addr];
    rd_sym   <= leaf_symbol[rd_addr];
  end

endmodule

// ----- design/hufd_out.sv -----
module hufd_out (
  input  logic                clk,
  input  logic                rst,
  input  hufd_pkg::res_req_t  res,
  output hufd_pkg::res_stat_t stat,
  output logic                out_valid,
  input  logic                out_ready,
  output hufd_pkg::out_item_t out_data
);
  import hufd_pkg::*;

  // one result is held back until we know whether it is the last of its item
  logic       pend_v;
  logic [6:0] pend_sym;
  logic       pend_err;
  logic       out_free;

  assign out_free      = !out_valid || out_ready;
  assign stat.push_ok  = !pend_v || out_free;
  assign stat.flush_ok = !pend_v || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (res.push) begin
        if (pend_v) begin
          out_data  <= '{symbol_out: pend_sym, error: pend_err, last: 1'b0};
          out_valid <= 1'b1;
        end else if (out_valid && out_ready) begin
          out_valid <= 1'b0;
        end
        pend_v   <= 1'b1;
        pend_sym <= res.symbol;
        pend_err <= res.error;
      end else if (res.flush && pend_v) begin
        out_data  <= '{symbol_out: pend_sym, error: pend_err, last: 1'b1};
        out_valid <= 1'b1;
        pend_v    <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/hufd_ctrl.sv -----
module hufd_ctrl #(
  parameter int NUM_NODES = 256,
  parameter int MAX_CODE_LEN = 32,
  localparam int NW = $clog2(NUM_NODES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hufd_pkg::in_item_t  in_data,
  output hufd_pkg::fld_mask_t wr_en,
  output logic [NW-1:0]       wr_addr,
  output logic [NW-1:0]       wr_child,
  output logic [6:0]          wr_sym,
  output logic [NW-1:0]       rd_addr,
  input  logic [NW-1:0]       rd_left,
  input  logic [NW-1:0]       rd_right,
  input  logic [6:0]          rd_sym,
  output hufd_pkg::res_req_t  res,
  input  hufd_pkg::res_stat_t stat
);
  import hufd_pkg::*;

  `include "huffman_tree_decoder_defines.svh"

  localparam int UW = $clog2(NUM_NODES + 1);
  localparam int LW = $clog2(MAX_CODE_LEN + 1);

  state_t state, state_next;

  // walk state: root children live in flops, other nodes in the store
  logic          at_root;
  logic [NW-1:0] root_left, root_right;
  logic [NW-1:0] cur_left, cur_right;
  logic [NW-1:0] tgt;
  logic [UW-1:0] nodes_used;

  logic [7:0]    byte_sh;
  logic [3:0]    bits_left;

  logic [NW-1:0] node;
  logic [NW-1:0] new_node;
  logic [LW-1:0] ld_left;
  logic [31:0]   code;
  logic [6:0]    symbol_r;

  logic [NW-1:0] dec_left, dec_right, nxt_child;
  logic          rd_leaf;
  logic [LW-1:0] ld_pos;
  logic          ld_bit;
  logic [NW-1:0] ld_kid_l, ld_kid_r, ld_slot;
  logic          tbl_full;

  assign dec_left  = at_root ? root_left  : cur_left;
  assign dec_right = at_root ? root_right : cur_right;
  assign nxt_child = byte_sh[7] ? dec_right : dec_left;
  assign rd_leaf   = (rd_left == '0) && (rd_right == '0);

  assign ld_pos   = ld_left - LW'(1);
  assign ld_bit   = (32'(ld_pos) < 32) && code[5'(ld_pos)];
  assign ld_kid_l = (node == '0) ? root_left  : rd_left;
  assign ld_kid_r = (node == '0) ? root_right : rd_right;
  assign ld_slot  = ld_bit ? ld_kid_r : ld_kid_l;
  assign tbl_full = 32'(nodes_used) >= NUM_NODES;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.req_type)
            REQ_LOAD: state_next = ST_LD_RD;
            REQ_DATA: state_next = ST_DEC_BIT;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_DEC_BIT: begin
        if (bits_left == 4'd0) begin
          state_next = ST_FLUSH;
        end else if (nxt_child != '0) begin
          state_next = ST_DEC_CHK;
        end
      end
      ST_DEC_CHK: begin
        if (!rd_leaf || stat.push_ok) begin
          state_next = ST_DEC_BIT;
        end
      end
      ST_LD_RD: begin
        state_next = (ld_left == '0) ? ST_LD_SYM : ST_LD_BIT;
      end
      ST_LD_BIT: begin
        if (ld_slot != '0) begin
          state_next = ST_LD_RD;
        end else if (tbl_full) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_LD_LINK;
        end
      end
      ST_LD_LINK: state_next = ST_LD_RD;
      ST_LD_SYM:  state_next = ST_IDLE;
      ST_FLUSH: begin
        if (stat.flush_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    res      = '0;
    wr_en    = WR_NONE;
    wr_addr  = node;
    wr_child = '0;
    wr_sym   = symbol_r;
    rd_addr  = tgt;
    case (state)
      ST_DEC_BIT: begin
        rd_addr = nxt_child;
        if (bits_left != 4'd0 && nxt_child == '0 && stat.push_ok) begin
          res.push  = 1'b1;
          res.error = 1'b1;
        end
      end
      ST_DEC_CHK: begin
        if (rd_leaf && stat.push_ok) begin
          res.push   = 1'b1;
          res.symbol = rd_sym;
        end
      end
      ST_LD_RD: rd_addr = node;
      ST_LD_BIT: begin
        if (ld_slot == '0) begin
          if (tbl_full) begin
            res.push  = 1'b1;
            res.error = 1'b1;
          end else begin
            // fresh node: no children, symbol zero
            wr_en   = WR_ALL;
            wr_addr = NW'(nodes_used);
            wr_sym  = 7'd0;
          end
        end
      end
      ST_LD_LINK: begin
        if (node != '0) begin
          wr_en    = ld_bit ? WR_RIGHT : WR_LEFT;
          wr_child = new_node;
        end
      end
      ST_LD_SYM: wr_en = WR_SYM;
      ST_FLUSH:  res.flush = stat.flush_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      at_root    <= 1'b1;
      root_left  <= '0;
      root_right <= '0;
      nodes_used <= UW'(1);
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            case (in_data.req_type)
              REQ_LOAD: begin
                node     <= '0;
                code     <= in_data.code_bits;
                symbol_r <= in_data.symbol;
                at_root  <= 1'b1;
                if (32'(in_data.code_len) > MAX_CODE_LEN) begin
                  ld_left <= LW'(MAX_CODE_LEN);
                end else begin
                  ld_left <= LW'(in_data.code_len);
                end
              end
              REQ_DATA: begin
                byte_sh   <= in_data.data_byte;
                bits_left <= (in_data.valid_bits > 4'd8) ? 4'd8 : in_data.valid_bits;
              end
              REQ_CLEAR: begin
                root_left  <= '0;
                root_right <= '0;
                nodes_used <= UW'(1);
                at_root    <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_DEC_BIT: begin
          if (bits_left != 4'd0) begin
            if (nxt_child == '0) begin
              // missing branch: hold until the result fits, then restart at root
              if (stat.push_ok) begin
                at_root   <= 1'b1;
                byte_sh   <= {byte_sh[6:0], 1'b0};
                bits_left <= bits_left - 4'd1;
              end
            end else begin
              tgt       <= nxt_child;
              byte_sh   <= {byte_sh[6:0], 1'b0};
              bits_left <= bits_left - 4'd1;
            end
          end
        end
        ST_DEC_CHK: begin
          if (rd_leaf) begin
            if (stat.push_ok) begin
              at_root <= 1'b1;
            end
          end else begin
            at_root   <= 1'b0;
            cur_left  <= rd_left;
            cur_right <= rd_right;
          end
        end
        ST_LD_BIT: begin
          if (ld_slot != '0) begin
            node    <= ld_slot;
            ld_left <= ld_left - LW'(1);
          end else if (!tbl_full) begin
            new_node   <= NW'(nodes_used);
            nodes_used <= nodes_used + UW'(1);
          end
        end
        ST_LD_LINK: begin
          if (node == '0) begin
            if (ld_bit) begin
              root_right <= new_node;
            end else begin
              root_left <= new_node;
            end
          end
          node    <= new_node;
          ld_left <= ld_left - LW'(1);
        end
        default: ;
      endcase
    end
  end

  `HUFD_ASSERT_IMP(a_nodes_range, 1'b1, nodes_used >= UW'(1) && 32'(nodes_used) <= NUM_NODES, "node count out of range")
  `HUFD_ASSERT_IMP(a_push_room, res.push, stat.push_ok, "result pushed with no buffer room")
  `HUFD_ASSERT_IMP(a_chk_entry, state == ST_DEC_CHK, $past(state) == ST_DEC_BIT || $past(state) == ST_DEC_CHK, "node check without a preceding read")
  `HUFD_ASSERT_NXT(a_load_root, state == ST_IDLE && in_valid && in_data.req_type == REQ_LOAD, at_root && node == '0, "load did not restart at root")

endmodule

// ----- design/huffman_tree_decoder.sv -----
// Channel   Signals                        Payload
// --------  -----------------------------  ---------------------------------------
// in        in_valid / in_ready            in_data  (req_type, symbol, code, byte)
// out       out_valid / out_ready          out_data (symbol_out, error, last)
//
// Data byte: each bit that reaches a node is one read of the node store (DEC_BIT,
// then DEC_CHK); a missing-branch bit gives an error result with no read. Load
// reads each node on the code path and writes a new node where a branch is
// missing. Clear only resets flops: root children and the node count sit there.
// Synchronous reset gives an empty tree at once. in_ready drops while an item
// is in work; a stalled output holds up to two results, then pauses the walk.
module huffman_tree_decoder #(
  parameter int NUM_NODES = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hufd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hufd_pkg::out_item_t out_data
);
  import hufd_pkg::*;

  localparam int NW = $clog2(NUM_NODES);

  fld_mask_t     wr_en;
  logic [NW-1:0] wr_addr;
  logic [NW-1:0] wr_child;
  logic [6:0]    wr_sym;
  logic [NW-1:0] rd_addr;
  logic [NW-1:0] rd_left;
  logic [NW-1:0] rd_right;
  logic [6:0]    rd_sym;
  res_req_t      res;
  res_stat_t     stat;

  hufd_ctrl #(
    .NUM_NODES    (NUM_NODES),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_child (wr_child),
    .wr_sym   (wr_sym),
    .rd_addr  (rd_addr),
    .rd_left  (rd_left),
    .rd_right (rd_right),
    .rd_sym   (rd_sym),
    .res      (res),
    .stat     (stat)
  );

  hufd_node_mem #(
    .NUM_NODES (NUM_NODES)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_child (wr_child),
    .wr_sym   (wr_sym),
    .rd_addr  (rd_addr),
    .rd_left  (rd_left),
    .rd_right (rd_right),
    .rd_sym   (rd_sym)
  );

  hufd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import hufd_pkg::*;

  localparam int NODES = 256;
  localparam int CODE_CAP = 32;
  localparam int RANDOM_ITEMS = 500;
  localparam int TAIL_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  huffman_tree_decoder #(
    .NUM_NODES(NODES),
    .MAX_CODE_LEN(CODE_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // shadow code tree; index 0 is the root and doubles as "no child"
  logic [7:0] t_left [NODES];
  logic [7:0] t_right [NODES];
  logic [6:0] t_sym [NODES];
  int unsigned t_used;
  logic [7:0] t_walk;

  out_item_t decoded_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned full_hits = 0;
  int unsigned burst_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void tree_clear();
    foreach (t_left[i]) begin
      t_left[i] = '0;
      t_right[i] = '0;
      t_sym[i] = '0;
    end
    t_used = 1;
    t_walk = '0;
  endfunction

  function automatic void tree_load(input in_item_t it);
    int unsigned len;
    logic [7:0] node;
    logic [7:0] nxt;
    logic b;
    len = 32'(it.code_len);
    if (len > CODE_CAP) len = CODE_CAP;
    node = '0;
    t_walk = '0;
    for (int i = 0; i < int'(len); i++) begin
      b = it.code_bits[int'(len) - 1 - i];
      nxt = b ? t_right[node] : t_left[node];
      if (nxt == '0) begin
        if (t_used >= NODES) begin
          decoded_q.insert(decoded_q.size(),
                           out_item_t'{symbol_out: 7'd0, error: 1'b1, last: 1'b1});
          full_hits++;
          return;
        end
        nxt = t_used[7:0];
        t_used++;
        t_left[nxt] = '0;
        t_right[nxt] = '0;
        t_sym[nxt] = '0;
        if (b) t_right[node] = nxt;
        else t_left[node] = nxt;
      end
      node = nxt;
    end
    t_sym[node] = it.symbol;
  endfunction

  function automatic void tree_decode(input in_item_t it);
    int unsigned nv;
    logic [7:0] nxt;
    out_item_t res[$];
    nv = (it.valid_bits > 4'd8) ? 8 : 32'(it.valid_bits);
    for (int j = 0; j < int'(nv); j++) begin
      nxt = it.data_byte[7 - j] ? t_right[t_walk] : t_left[t_walk];
      if (nxt == '0) begin
        res.insert(res.size(), out_item_t'{symbol_out: 7'd0, error: 1'b1, last: 1'b0});
        t_walk = '0;
      end else if (t_left[nxt] == '0 && t_right[nxt] == '0) begin
        res.insert(res.size(), out_item_t'{symbol_out: t_sym[nxt], error: 1'b0, last: 1'b0});
        t_walk = '0;
      end else begin
        t_walk = nxt;
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[k]) decoded_q.insert(decoded_q.size(), res[k]);
  endfunction

  function automatic void tree_predict(input in_item_t it);
    case (it.req_type)
      REQ_LOAD: tree_load(it);
      REQ_DATA: tree_decode(it);
      REQ_CLEAR: tree_clear();
      default: ;
    endcase
  endfunction

  // unused fields carry random bits so the block has to ignore them
  function automatic in_item_t load_item(input logic [6:0] sym, input logic [31:0] bits,
                                         input logic [5:0] len);
    in_item_t it;
    it = '{req_type: REQ_LOAD, symbol: sym, code_bits: bits, code_len: len,
           data_byte: 8'($urandom), valid_bits: 4'($urandom)};
    return it;
  endfunction

  function automatic in_item_t data_item(input logic [7:0] data, input logic [3:0] nv);
    in_item_t it;
    it = '{req_type: REQ_DATA, symbol: 7'($urandom), code_bits: $urandom,
           code_len: 6'($urandom), data_byte: data, valid_bits: nv};
    return it;
  endfunction

  function automatic in_item_t plain_item(input logic [1:0] req);
    in_item_t it;
    it = '{req_type: req, symbol: 7'($urandom), code_bits: $urandom,
           code_len: 6'($urandom), data_byte: 8'($urandom), valid_bits: 4'($urandom)};
    return it;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it = '{req_type: 2'($urandom_range(0, 3)), symbol: 7'($urandom), code_bits: $urandom,
           code_len: 6'($urandom_range(0, 63)), data_byte: 8'($urandom),
           valid_bits: 4'($urandom_range(0, 15))};
    return it;
  endfunction

  // valid stays high across a burst; drop it only for a gap
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tree_predict(it);
    if (it.req_type != REQ_UNUSED) items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic release_bus();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    release_bus();
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_tree();
    send_item(data_item(8'h00, 4'd8));
    send_item(data_item(8'hFF, 4'd15));
    send_item(data_item(8'hA5, 4'd0));
    send_item(plain_item(REQ_UNUSED));
    send_item(plain_item(REQ_CLEAR));
    send_item(data_item(8'h5A, 4'd9));
  endtask

  task automatic test_prefix_code();
    send_item(plain_item(REQ_CLEAR));
    send_item(load_item(7'd5, 32'b0, 6'd1));
    send_item(load_item(7'd127, 32'b10, 6'd2));
    send_item(load_item(7'd0, 32'b110, 6'd3));
    send_item(load_item(7'd64, 32'b111, 6'd3));
    send_item(data_item(8'h00, 4'd8));
    // ends two bits into a code; the next byte finishes it
    send_item(data_item(8'hFF, 4'd8));
    send_item(data_item(8'h80, 4'd1));
    send_item(data_item(8'b1011_0111, 4'd8));
    send_item(data_item(8'h60, 4'd3));
    // clear in the middle of a walk
    send_item(plain_item(REQ_CLEAR));
    wait_drained();
    send_item(data_item(8'hC0, 4'd2));
  endtask

  task automatic test_odd_loads();
    send_item(plain_item(REQ_CLEAR));
    send_item(load_item(7'd9, 32'hFFFF_FFFF, 6'd0));
    send_item(load_item(7'd3, 32'b1, 6'd1));
    send_item(data_item(8'h00, 4'd2));
    send_item(load_item(7'd17, 32'b01, 6'd2));
    // missing branch mid-byte, then decode resumes from the root
    send_item(data_item(8'h18, 4'd5));
    // grow children under an existing leaf
    send_item(load_item(7'd21, 32'b10, 6'd2));
    send_item(data_item(8'h80, 4'd1));
    send_item(data_item(8'h00, 4'd1));
    send_item(load_item(7'd33, 32'b1, 6'd1));
    send_item(data_item(8'hC0, 4'd2));
    send_item(load_item(7'd77, 32'hFFFF_FFFF, 6'd63));
    repeat (4) send_item(data_item(8'hFF, 4'd8));
    send_item(load_item(7'd100, 32'h8000_0001, 6'd40));
    repeat (4) send_item(data_item(8'h80, 4'd8));
    send_item(data_item(8'h01, 4'd8));
  endtask

  task automatic test_table_full();
    int unsigned start;
    logic [31:0] first_bits;
    logic [6:0] first_sym;
    send_item(plain_item(REQ_CLEAR));
    first_bits = $urandom;
    first_sym = 7'($urandom);
    send_item(load_item(first_sym, first_bits, 6'd32));
    start = full_hits;
    while (full_hits == start) send_item(load_item(7'($urandom), $urandom, 6'd32));
    send_item(load_item(7'($urandom), ~first_bits, 6'd32));
    send_item(load_item(first_sym, first_bits, 6'd32));
    for (int k = 3; k >= 0; k--) send_item(data_item(first_bits[k * 8 +: 8], 4'd8));
    repeat (4) send_item(data_item(8'($urandom), 4'd8));
    wait_drained();
  endtask

  // random prefix codes, loaded and then fed with bitstreams built from them
  task automatic test_random_streams();
    int unsigned goal;
    int unsigned k_syms;
    int unsigned tries;
    int unsigned idx;
    int unsigned tmp;
    int unsigned n_msg;
    int unsigned c;
    logic [31:0] cb[$];
    int unsigned cl[$];
    logic [6:0] syms[$];
    int unsigned order[$];
    bit pend[$];
    logic [7:0] data;
    logic [3:0] nv;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      k_syms = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 128) : $urandom_range(2, 16);
      cb.delete();
      cl.delete();
      syms.delete();
      order.delete();
      cb.insert(cb.size(), 32'd0);
      cl.insert(cl.size(), 0);
      tries = 0;
      while (cb.size() < k_syms && tries < 2000) begin
        tries++;
        idx = $urandom_range(0, cb.size() - 1);
        if (cl[idx] < CODE_CAP) begin
          cb.insert(cb.size(), (cb[idx] << 1) | 32'd1);
          cl.insert(cl.size(), cl[idx] + 1);
          cb[idx] = cb[idx] << 1;
          cl[idx] = cl[idx] + 1;
        end
      end
      foreach (cb[i]) begin
        syms.insert(syms.size(), 7'($urandom));
        order.insert(order.size(), i);
      end
      for (int i = order.size() - 1; i > 0; i--) begin
        idx = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[idx];
        order[idx] = tmp;
      end
      if ($urandom_range(0, 7) != 0) send_item(plain_item(REQ_CLEAR));
      foreach (order[i]) send_item(load_item(syms[order[i]], cb[order[i]], 6'(cl[order[i]])));
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) send_item(noise_item());
      end
      n_msg = $urandom_range(1, 40);
      pend.delete();
      repeat (n_msg) begin
        idx = $urandom_range(0, cb.size() - 1);
        for (int b = int'(cl[idx]) - 1; b >= 0; b--) pend.insert(pend.size(), cb[idx][b]);
      end
      while (pend.size() > 0) begin
        c = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 8;
        if (c > pend.size()) c = pend.size();
        data = 8'($urandom);
        for (int b = 0; b < int'(c); b++) data[7 - b] = pend.pop_front();
        nv = 4'(c);
        if (c == 8 && $urandom_range(0, 9) == 0) nv = 4'($urandom_range(9, 15));
        send_item(data_item(data, nv));
        if ($urandom_range(0, 29) == 0) send_item(data_item(8'($urandom), 4'd0));
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin : rx_stall
    int unsigned mode;
    int unsigned span;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual sym %0d err %0b last %0b",
                 $time, out_data.symbol_out, out_data.error, out_data.last);
      end else begin
        want = decoded_q.pop_front();
        if (out_data.symbol_out !== want.symbol_out) begin
          mismatches++;
          $display("%0t: symbol_out expected %0d actual %0d",
                   $time, want.symbol_out, out_data.symbol_out);
        end
        if (out_data.error !== want.error) begin
          mismatches++;
          $display("%0t: error expected %0b actual %0b", $time, want.error, out_data.error);
        end
        if (out_data.last !== want.last) begin
          mismatches++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("huffman_tree_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    tree_clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_tree();
    test_prefix_code();
    test_odd_loads();
    test_table_full();
    test_random_streams();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("huffman_tree_decoder regression: pass");
    else $display("huffman_tree_decoder regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/hufd_pkg.sv
design/hufd_node_mem.sv
design/hufd_out.sv
design/hufd_ctrl.sv
design/huffman_tree_decoder.sv
dv/tb.sv
